// ----- rtl/indexed_min_heap_decrease_key_macros.svh -----
// Assertion helpers used by the heap core.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_MACROS_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_MACROS_SVH

// Checked on every clock edge outside of reset.
`define IMHDK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IMHDK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/imhdk_pkg.sv -----
package imhdk_pkg;

  localparam int unsigned Capacity    = 1024;
  localparam int unsigned HandleSpace = 1024;

  localparam int unsigned AddrW  = $clog2(Capacity);
  localparam int unsigned CntW   = $clog2(Capacity + 1);
  localparam int unsigned ChildW = AddrW + 2;
  localparam int unsigned HdlW   = $clog2(HandleSpace);
  localparam int unsigned OpW    = $clog2(HandleSpace + 1);

  localparam int unsigned KeyW    = 32;
  localparam int unsigned HFieldW = 11;
  localparam int unsigned FuncW   = 2;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);
  localparam logic [OpW-1:0]  HsOp   = OpW'(HandleSpace);

  typedef enum logic [FuncW-1:0] {
    FN_PUSH     = 2'd0,
    FN_EXTRACT  = 2'd1,
    FN_DECREASE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DEAD  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DEC_CHK,
    S_EX0,
    S_EX1,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [HdlW-1:0]        hdl;
  } heap_ent_t;

  typedef struct packed {
    logic             live;
    logic [AddrW-1:0] pos;
  } pos_ent_t;

  typedef struct packed {
    status_e                status;
    logic signed [KeyW-1:0] min_key;
    logic [HFieldW-1:0]     min_handle;
  } result_t;

endpackage

// ----- rtl/imhdk_if.sv -----
interface imhdk_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [imhdk_pkg::FuncW-1:0]          func;
  logic signed [imhdk_pkg::KeyW-1:0]    key;
  logic [imhdk_pkg::HFieldW-1:0]        handle;

  modport source (output valid, output func, output key, output handle, input ready);
  modport sink (input valid, input func, input key, input handle, output ready);
endinterface

interface imhdk_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [imhdk_pkg::KeyW-1:0]    min_key;
  logic [imhdk_pkg::HFieldW-1:0]        min_handle;

  modport source (output valid, output status, output min_key, output min_handle,
                  input ready);
  modport sink (input valid, input status, input min_key, input min_handle,
                output ready);
endinterface

// ----- rtl/imhdk_ram.sv -----
module imhdk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/imhdk_core.sv -----
`include "indexed_min_heap_decrease_key_macros.svh"

module imhdk_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  imhdk_in_if.sink            in_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output imhdk_pkg::result_t  res_o
);

  imhdk_pkg::state_e    state_q, state_d;
  logic [imhdk_pkg::FuncW-1:0]   func_q, func_d;
  logic signed [imhdk_pkg::KeyW-1:0] key_q, key_d;
  logic [imhdk_pkg::HFieldW-1:0] hdl_q, hdl_d;
  logic [imhdk_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [imhdk_pkg::OpW-1:0]     op_q, op_d;
  imhdk_pkg::heap_ent_t cur_q, cur_d;
  imhdk_pkg::heap_ent_t child_q, child_d;
  logic [imhdk_pkg::AddrW-1:0]   idx_q, idx_d;
  logic                          has_r_q, has_r_d;
  imhdk_pkg::result_t   res_q, res_d;

  // Memory ports.
  logic                                 hp_we, hp_re;
  logic [imhdk_pkg::AddrW-1:0]          hp_waddr, hp_raddr;
  imhdk_pkg::heap_ent_t                 hp_wdata;
  logic [$bits(imhdk_pkg::heap_ent_t)-1:0] hp_rdata;
  logic                                 ps_we, ps_re;
  logic [imhdk_pkg::HdlW-1:0]           ps_waddr, ps_raddr;
  imhdk_pkg::pos_ent_t                  ps_wdata;
  logic [$bits(imhdk_pkg::pos_ent_t)-1:0] ps_rdata;

  imhdk_pkg::heap_ent_t rd_ent, pick;
  imhdk_pkg::pos_ent_t  ps_ent;
  logic [imhdk_pkg::AddrW-1:0]  parent_idx, pick_idx;
  logic [imhdk_pkg::ChildW-1:0] left_c, right_c;
  logic [imhdk_pkg::HFieldW-1:0] hdl_m1;
  logic [imhdk_pkg::CntW-1:0]   last_c;
  logic left_in, right_in, push_full, hdl_dead, up_move, pick_right, dn_stop;
  logic op_room, in_fire;

  imhdk_ram #(
    .Width($bits(imhdk_pkg::heap_ent_t)),
    .Depth(imhdk_pkg::Capacity)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (hp_we),
    .waddr_i(hp_waddr),
    .wdata_i(hp_wdata),
    .re_i   (hp_re),
    .raddr_i(hp_raddr),
    .rdata_o(hp_rdata)
  );

  imhdk_ram #(
    .Width($bits(imhdk_pkg::pos_ent_t)),
    .Depth(imhdk_pkg::HandleSpace)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (ps_we),
    .waddr_i(ps_waddr),
    .wdata_i(ps_wdata),
    .re_i   (ps_re),
    .raddr_i(ps_raddr),
    .rdata_o(ps_rdata)
  );

  assign rd_ent     = imhdk_pkg::heap_ent_t'(hp_rdata);
  assign ps_ent     = imhdk_pkg::pos_ent_t'(ps_rdata);
  assign parent_idx = (idx_q - imhdk_pkg::AddrW'(1)) >> 1;
  assign left_c     = {1'b0, idx_q, 1'b1};
  assign right_c    = left_c + imhdk_pkg::ChildW'(1);
  assign left_in    = left_c < imhdk_pkg::ChildW'(cnt_q);
  assign right_in   = right_c < imhdk_pkg::ChildW'(cnt_q);
  assign last_c     = cnt_q - imhdk_pkg::CntW'(1);
  assign op_room    = op_q != imhdk_pkg::HsOp;
  assign push_full  = (cnt_q == imhdk_pkg::CapCnt) || !op_room;
  assign hdl_m1     = hdl_q - imhdk_pkg::HFieldW'(1);
  assign hdl_dead   = (hdl_q == '0) || (32'(hdl_q) > 32'(op_q));
  assign up_move    = cur_q.key < rd_ent.key;
  assign pick_right = has_r_q && (rd_ent.key < child_q.key);
  assign pick       = pick_right ? rd_ent : child_q;
  assign pick_idx   = pick_right ? right_c[imhdk_pkg::AddrW-1:0]
                                 : left_c[imhdk_pkg::AddrW-1:0];
  assign dn_stop    = cur_q.key < pick.key;
  assign in_fire    = in_i.valid && in_i.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      imhdk_pkg::S_IDLE: begin
        if (in_i.valid) state_d = imhdk_pkg::S_START;
      end
      imhdk_pkg::S_START: begin
        case (func_q)
          imhdk_pkg::FN_PUSH:
            state_d = push_full ? imhdk_pkg::S_DONE : imhdk_pkg::S_UP_RD;
          imhdk_pkg::FN_EXTRACT:
            state_d = (cnt_q == '0) ? imhdk_pkg::S_DONE : imhdk_pkg::S_EX0;
          imhdk_pkg::FN_DECREASE:
            state_d = hdl_dead ? imhdk_pkg::S_DONE : imhdk_pkg::S_DEC_CHK;
          default: state_d = imhdk_pkg::S_DONE;
        endcase
      end
      imhdk_pkg::S_DEC_CHK:
        state_d = ps_ent.live ? imhdk_pkg::S_UP_RD : imhdk_pkg::S_DONE;
      imhdk_pkg::S_EX0:
        state_d = (last_c == '0) ? imhdk_pkg::S_DONE : imhdk_pkg::S_EX1;
      imhdk_pkg::S_EX1: state_d = imhdk_pkg::S_DN_RDL;
      imhdk_pkg::S_UP_RD:
        state_d = (idx_q == '0) ? imhdk_pkg::S_DONE : imhdk_pkg::S_UP_CMP;
      imhdk_pkg::S_UP_CMP:
        state_d = up_move ? imhdk_pkg::S_UP_RD : imhdk_pkg::S_DONE;
      imhdk_pkg::S_DN_RDL:
        state_d = left_in ? imhdk_pkg::S_DN_RDR : imhdk_pkg::S_DONE;
      imhdk_pkg::S_DN_RDR: state_d = imhdk_pkg::S_DN_CMP;
      imhdk_pkg::S_DN_CMP:
        state_d = dn_stop ? imhdk_pkg::S_DONE : imhdk_pkg::S_DN_RDL;
      imhdk_pkg::S_DONE: begin
        if (res_ready_i) state_d = imhdk_pkg::S_IDLE;
      end
      default: state_d = imhdk_pkg::S_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    in_i.ready  = state_q == imhdk_pkg::S_IDLE;
    res_valid_o = state_q == imhdk_pkg::S_DONE;
    hp_we    = 1'b0;
    hp_waddr = idx_q;
    hp_wdata = cur_q;
    hp_re    = 1'b0;
    hp_raddr = '0;
    ps_we    = 1'b0;
    ps_waddr = cur_q.hdl;
    ps_wdata = '{live: 1'b1, pos: idx_q};
    ps_re    = 1'b0;
    ps_raddr = hdl_m1[imhdk_pkg::HdlW-1:0];
    case (state_q)
      imhdk_pkg::S_START: begin
        // While operation slots remain, every item marks its own slot as not live; a good push sets it later.
        if (op_room) begin
          ps_we    = 1'b1;
          ps_waddr = op_q[imhdk_pkg::HdlW-1:0];
          ps_wdata = '0;
        end
        if (func_q == imhdk_pkg::FN_EXTRACT && cnt_q != '0) begin
          hp_re = 1'b1;
        end
        if (func_q == imhdk_pkg::FN_DECREASE && !hdl_dead) begin
          ps_re = 1'b1;
        end
      end
      imhdk_pkg::S_EX0: begin
        ps_we    = 1'b1;
        ps_waddr = rd_ent.hdl;
        ps_wdata = '0;
        if (last_c != '0) begin
          hp_re    = 1'b1;
          hp_raddr = last_c[imhdk_pkg::AddrW-1:0];
        end
      end
      imhdk_pkg::S_UP_RD: begin
        if (idx_q == '0) begin
          hp_we = 1'b1;
          ps_we = 1'b1;
        end else begin
          hp_re    = 1'b1;
          hp_raddr = parent_idx;
        end
      end
      imhdk_pkg::S_UP_CMP: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
        if (up_move) begin
          hp_wdata = rd_ent;
          ps_waddr = rd_ent.hdl;
        end
      end
      imhdk_pkg::S_DN_RDL: begin
        if (left_in) begin
          hp_re    = 1'b1;
          hp_raddr = left_c[imhdk_pkg::AddrW-1:0];
        end else begin
          hp_we = 1'b1;
          ps_we = 1'b1;
        end
      end
      imhdk_pkg::S_DN_RDR: begin
        hp_re    = right_in;
        hp_raddr = right_c[imhdk_pkg::AddrW-1:0];
      end
      imhdk_pkg::S_DN_CMP: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
        if (!dn_stop) begin
          hp_wdata = pick;
          ps_waddr = pick.hdl;
        end
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    func_d  = func_q;
    key_d   = key_q;
    hdl_d   = hdl_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    cur_d   = cur_q;
    child_d = child_q;
    idx_d   = idx_q;
    has_r_d = has_r_q;
    res_d   = res_q;
    case (state_q)
      imhdk_pkg::S_IDLE: begin
        func_d = in_i.func;
        key_d  = in_i.key;
        hdl_d  = in_i.handle;
      end
      imhdk_pkg::S_START: begin
        res_d = '{status: imhdk_pkg::ST_OK, min_key: '0, min_handle: '0};
        if (op_room) op_d = op_q + imhdk_pkg::OpW'(1);
        case (func_q)
          imhdk_pkg::FN_PUSH: begin
            if (push_full) begin
              res_d.status = imhdk_pkg::ST_FULL;
            end else begin
              cur_d = '{key: key_q, hdl: op_q[imhdk_pkg::HdlW-1:0]};
              idx_d = cnt_q[imhdk_pkg::AddrW-1:0];
              cnt_d = cnt_q + imhdk_pkg::CntW'(1);
            end
          end
          imhdk_pkg::FN_EXTRACT: begin
            if (cnt_q == '0) res_d.status = imhdk_pkg::ST_EMPTY;
          end
          imhdk_pkg::FN_DECREASE: begin
            if (hdl_dead) res_d.status = imhdk_pkg::ST_DEAD;
          end
          default: ;
        endcase
      end
      imhdk_pkg::S_DEC_CHK: begin
        cur_d = '{key: key_q, hdl: hdl_m1[imhdk_pkg::HdlW-1:0]};
        idx_d = ps_ent.pos;
        if (!ps_ent.live) res_d.status = imhdk_pkg::ST_DEAD;
      end
      imhdk_pkg::S_EX0: begin
        res_d.min_key    = rd_ent.key;
        res_d.min_handle = imhdk_pkg::HFieldW'(rd_ent.hdl) + imhdk_pkg::HFieldW'(1);
        cnt_d            = last_c;
      end
      imhdk_pkg::S_EX1: begin
        cur_d = rd_ent;
        idx_d = '0;
      end
      imhdk_pkg::S_UP_CMP: begin
        if (up_move) idx_d = parent_idx;
      end
      imhdk_pkg::S_DN_RDR: begin
        child_d = rd_ent;
        has_r_d = right_in;
      end
      imhdk_pkg::S_DN_CMP: begin
        if (!dn_stop) idx_d = pick_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imhdk_pkg::S_IDLE;
      cnt_q   <= '0;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    key_q   <= key_d;
    hdl_q   <= hdl_d;
    cur_q   <= cur_d;
    child_q <= child_d;
    idx_q   <= idx_d;
    has_r_q <= has_r_d;
    res_q   <= res_d;
  end

  assign res_o = res_q;

  `IMHDK_ASSERT(a_cnt_bound, (cnt_q <= imhdk_pkg::CapCnt), "heap count beyond capacity")
  `IMHDK_ASSERT(a_accept_start, in_fire |=> (state_q == imhdk_pkg::S_START), "accept did not start")
  `IMHDK_ASSERT(a_heap_rw, !(hp_we && hp_re && (hp_waddr == hp_raddr)), "heap read and write collide")
  `IMHDK_ASSERT(a_op_mono, (op_q >= $past(op_q)), "operation count went backward")
  `IMHDK_ASSERT_ALWAYS(a_idle_quiet, (state_q == imhdk_pkg::S_IDLE) |-> !(hp_we || ps_we), "write while idle")

endmodule

// ----- rtl/indexed_min_heap_decrease_key.sv -----
// Indexed binary min-heap of signed 32-bit keys with decrease-key.
// The in_i channel carries one word per operation: func selects push, extract
// minimum or decrease key; key is the pushed or new key; handle names a push
// by its one-based operation number. While operation slots remain, every
// accepted word takes the next slot, and a push becomes live under its number.
// The out_o channel returns exactly one word per input word: status, and on a
// successful extract the minimum key and its handle.
// Heap entries and the handle-to-position table live in two synchronous
// memories. Sifting walks one tree level per iteration, going up through the
// states S_UP_RD and S_UP_CMP and going down through S_DN_RDL, S_DN_RDR and
// S_DN_CMP; an extract sinks through at most nine levels. One operation is in
// flight at a time. Reset clears the heap count, the operation count and the
// control state; the memories need no clearing pass, since every slot is
// written before a decrease can name it. If the receiver stalls, the
// finished word waits in the output register and the next operation still
// runs; a further result then waits in the core until the output register
// frees.
module indexed_min_heap_decrease_key (
  input  logic        clk_i,
  input  logic        rst_ni,
  imhdk_in_if.sink    in_i,
  imhdk_out_if.source out_o
);

  logic               res_valid;
  logic               res_ready;
  imhdk_pkg::result_t res;
  imhdk_pkg::result_t out_q;
  logic               out_valid_q;

  imhdk_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // The output register takes a new word whenever it is empty or draining.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_q.status;
  assign out_o.min_key    = out_q.min_key;
  assign out_o.min_handle = out_q.min_handle;

endmodule
